/* rtl/core/assert_macros.svh */
// Assertion macros shared by the drive command ramp queue RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define DRCQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DRCQ_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) cond |=> prop) else $error(msg);
`else
`define DRCQ_ASSERT(label, clk, rst, prop, msg)
`define DRCQ_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif
`endif

/* rtl/core/drcq_pkg.sv */
package drcq_pkg;

   localparam int BYTE_W      = 8;
   localparam int DUTY_W      = 7;
   localparam int PWM_W       = 8;
   localparam int TICK_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [DUTY_W-1:0] DUTY_MAX          = 7'd100;
   localparam logic [DUTY_W-1:0] START_DUTY_RESET  = 7'd60;
   localparam logic [DUTY_W-1:0] DUTY_STEP_RESET   = 7'd10;
   localparam logic [TICK_W-1:0] PERIOD_RESET      = 16'd31250;
   localparam logic [PWM_W-1:0]  PWM_FULL          = 8'd255;

   // duty*255/100 is computed as duty*PWM_RECIP >> PWM_SHIFT, exact for 7-bit duty.
   localparam int                PWM_SHIFT = 19;
   localparam logic [20:0]       PWM_RECIP = 21'd1336965;

   localparam logic [BYTE_W-1:0] CHAR_F = 8'h46;
   localparam logic [BYTE_W-1:0] CHAR_B = 8'h42;
   localparam logic [BYTE_W-1:0] CHAR_L = 8'h4C;
   localparam logic [BYTE_W-1:0] CHAR_R = 8'h52;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_DUTY   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_STEP    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_TICKS = 2'd2;

   typedef enum logic [2:0] {
      DIR_NONE = 3'd0,
      DIR_F    = 3'd1,
      DIR_B    = 3'd2,
      DIR_L    = 3'd3,
      DIR_R    = 3'd4
   } dir_type;

   typedef struct packed {
      logic [PWM_W-1:0] left_pwm;
      logic             left_reverse;
      logic [PWM_W-1:0] right_pwm;
      logic             right_reverse;
   } drive_type;

   typedef struct packed {
      logic              clear;
      logic              push;
      logic              pop;
      logic [DUTY_W-1:0] push_duty;
   } queue_req_type;

   typedef struct packed {
      logic              empty;
      logic              full;
      logic [DUTY_W-1:0] head_duty;
   } queue_stat_type;

   function automatic dir_type code_of(logic [BYTE_W-1:0] b);
      dir_type c;
      case (b)
         CHAR_F:  c = DIR_F;
         CHAR_B:  c = DIR_B;
         CHAR_L:  c = DIR_L;
         CHAR_R:  c = DIR_R;
         default: c = DIR_NONE;
      endcase
      return c;
   endfunction

   function automatic logic [PWM_W-1:0] pwm_of(logic [DUTY_W-1:0] duty);
      logic [27:0] prod;
      logic [8:0]  quo;
      prod = 28'(duty) * 28'(PWM_RECIP);
      quo  = prod[27:PWM_SHIFT];
      return (quo > 9'(PWM_FULL)) ? PWM_FULL : quo[PWM_W-1:0];
   endfunction

endpackage

/* rtl/core/drcq_req_if.sv */
interface drcq_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [drcq_pkg::BYTE_W-1:0] byte_value;

   modport source (output valid, output opcode, output byte_value, input ready);
   modport sink   (input valid, input opcode, input byte_value, output ready);
endinterface

/* rtl/core/drcq_rsp_if.sv */
interface drcq_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [drcq_pkg::PWM_W-1:0] left_pwm;
   logic                       left_reverse;
   logic [drcq_pkg::PWM_W-1:0] right_pwm;
   logic                       right_reverse;
   logic                       timer_running;

   modport source (output valid, output left_pwm, output left_reverse, output right_pwm,
                   output right_reverse, output timer_running, input ready);
   modport sink   (input valid, input left_pwm, input left_reverse, input right_pwm,
                   input right_reverse, input timer_running, output ready);
endinterface

/* rtl/core/drcq_csr_if.sv */
interface drcq_csr_if;
   logic                             valid;
   logic                             ready;
   logic [drcq_pkg::CSR_INDEX_W-1:0] index;
   logic [drcq_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/drcq_queue.sv */
`include "assert_macros.svh"

module drcq_queue #(
   parameter int QUEUE_DEPTH = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  drcq_pkg::queue_req_type  queue_req,
   output drcq_pkg::queue_stat_type queue_stat
);
   import drcq_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [DUTY_W-1:0] mem [QUEUE_DEPTH];
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DUTY_W-1:0] head_duty_ff;

   logic              full;
   logic              we;
   logic [IDX_W-1:0]  waddr;
   logic [IDX_W-1:0]  head_inc;
   logic [SUM_W-1:0]  tail_sum;
   logic [IDX_W-1:0]  tail;

   always_comb begin
      full     = (count_ff == CNT_W'(QUEUE_DEPTH));
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
         tail = IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
      end else begin
         tail = IDX_W'(tail_sum);
      end
      if (head_ff == IDX_W'(QUEUE_DEPTH - 1)) begin
         head_inc = '0;
      end else begin
         head_inc = head_ff + IDX_W'(1);
      end

      if (queue_req.clear) begin
         // A new ramp empties the ring and loads the start duty at slot zero.
         we       = 1'b1;
         waddr    = '0;
         head_in  = '0;
         count_in = CNT_W'(1);
      end else begin
         we       = queue_req.push && !full;
         waddr    = tail;
         head_in  = queue_req.pop ? head_inc : head_ff;
         count_in = count_ff + CNT_W'(we) - CNT_W'(queue_req.pop);
      end

      queue_stat.empty     = (count_ff == '0);
      queue_stat.full      = full;
      queue_stat.head_duty = head_duty_ff;
   end

   // The entry at the next head is read ahead so that a dequeue never waits on a memory read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= queue_req.push_duty;
      end
      if (we && (waddr == head_in)) begin
         head_duty_ff <= queue_req.push_duty;
      end else begin
         head_duty_ff <= mem[head_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   `DRCQ_ASSERT(a_count_bound, clock, reset, (count_ff <= CNT_W'(QUEUE_DEPTH)), "queue overfilled")
   `DRCQ_ASSERT(a_head_bound, clock, reset, (32'(head_ff) < QUEUE_DEPTH), "head out of range")
   `DRCQ_ASSERT_NEXT(a_clear_load, clock, reset, queue_req.clear, (count_ff == CNT_W'(1) && head_ff == '0), "clear did not leave one entry")

endmodule

/* rtl/core/drcq_ctrl.sv */
`include "assert_macros.svh"

module drcq_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              opcode,
   input  logic [drcq_pkg::BYTE_W-1:0]       byte_value,
   input  logic [drcq_pkg::DUTY_W-1:0]       start_duty,
   input  logic [drcq_pkg::DUTY_W-1:0]       duty_step,
   input  logic [drcq_pkg::TICK_W-1:0]       period_ticks,
   input  drcq_pkg::queue_stat_type          queue_stat,
   output drcq_pkg::queue_req_type           queue_req,
   output drcq_pkg::drive_type               drive,
   output logic                              timer_on
);
   import drcq_pkg::*;

   logic [DUTY_W-1:0] ramp_ff, ramp_in;
   dir_type           active_ff, active_in;
   dir_type           prev_ff, prev_in;
   logic              first_ff, first_in;
   logic              timer_ff, timer_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   drive_type         drive_ff, drive_in;

   dir_type           cmd;
   logic              is_cmd, is_new, is_repeat, is_tick;
   logic              expire, advance, push_ok, avail;
   logic [DUTY_W:0]   duty_sum;
   logic [DUTY_W-1:0] ramp_next, deq_duty;
   logic [PWM_W-1:0]  deq_pwm;

   always_comb begin
      cmd       = code_of(byte_value);
      is_cmd    = accept && !opcode && (cmd != DIR_NONE);
      is_new    = is_cmd && (cmd != prev_ff);
      is_repeat = is_cmd && (cmd == prev_ff);
      is_tick   = accept && opcode && timer_ff;
      expire    = (tick_ff >= period_ticks);

      duty_sum = {1'b0, ramp_ff} + {1'b0, duty_step};
      if (ramp_ff < DUTY_MAX) begin
         ramp_next = (duty_sum > {1'b0, DUTY_MAX}) ? DUTY_MAX : duty_sum[DUTY_W-1:0];
      end else begin
         ramp_next = ramp_ff;
      end

      // When the ring is empty, a repeat's own push is what the dequeue sees.
      push_ok  = is_repeat && !queue_stat.full;
      avail    = !queue_stat.empty || push_ok;
      deq_duty = queue_stat.empty ? ramp_next : queue_stat.head_duty;
      deq_pwm  = pwm_of(deq_duty);
      advance  = (is_repeat && first_ff) || (is_tick && expire);

      queue_req.clear     = is_new;
      queue_req.push      = is_repeat;
      queue_req.pop       = advance && avail;
      queue_req.push_duty = is_new ? start_duty : ramp_next;

      ramp_in   = ramp_ff;
      active_in = active_ff;
      prev_in   = prev_ff;
      first_in  = first_ff;
      timer_in  = timer_ff;
      tick_in   = tick_ff;
      drive_in  = drive_ff;

      if (is_new) begin
         ramp_in   = start_duty;
         active_in = cmd;
         prev_in   = cmd;
         first_in  = 1'b1;
         tick_in   = '0;
         timer_in  = 1'b1;
      end
      if (is_repeat) begin
         ramp_in = ramp_next;
         if (first_ff) begin
            first_in = 1'b0;
         end
      end
      if (is_tick) begin
         tick_in = expire ? '0 : tick_ff + TICK_W'(1);
      end
      if (advance) begin
         if (!avail) begin
            timer_in = 1'b0;
            drive_in = '0;
            // A repeated command keeps itself as the previous command.
            if (is_tick) begin
               prev_in = DIR_NONE;
            end
         end else begin
            case (active_ff)
               DIR_F: begin
                  drive_in = '{left_pwm: deq_pwm, left_reverse: 1'b0,
                               right_pwm: deq_pwm, right_reverse: 1'b0};
               end
               DIR_B: begin
                  drive_in = '{left_pwm: '0, left_reverse: 1'b1,
                               right_pwm: '0, right_reverse: 1'b1};
               end
               DIR_L: begin
                  drive_in = '{left_pwm: '0, left_reverse: 1'b0,
                               right_pwm: PWM_FULL, right_reverse: 1'b0};
               end
               DIR_R: begin
                  drive_in = '{left_pwm: PWM_FULL, left_reverse: 1'b0,
                               right_pwm: '0, right_reverse: 1'b0};
               end
               default: begin
                  drive_in = drive_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ff   <= START_DUTY_RESET;
         active_ff <= DIR_NONE;
         prev_ff   <= DIR_NONE;
         first_ff  <= 1'b0;
         timer_ff  <= 1'b0;
         tick_ff   <= '0;
         drive_ff  <= '0;
      end else begin
         ramp_ff   <= ramp_in;
         active_ff <= active_in;
         prev_ff   <= prev_in;
         first_ff  <= first_in;
         timer_ff  <= timer_in;
         tick_ff   <= tick_in;
         drive_ff  <= drive_in;
      end
   end

   assign drive    = drive_ff;
   assign timer_on = timer_ff;

   `DRCQ_ASSERT(a_reverse_pair, clock, reset, (drive_ff.left_reverse == drive_ff.right_reverse), "reverse bits differ")
   `DRCQ_ASSERT(a_reverse_no_pwm, clock, reset, (!drive_ff.left_reverse || (drive_ff.left_pwm == '0 && drive_ff.right_pwm == '0)), "reverse with forward PWM")
   `DRCQ_ASSERT_NEXT(a_new_starts, clock, reset, is_new, (timer_ff && first_ff), "new command did not start the timer")

endmodule

/* rtl/core/drive_command_ramp_queue_unit.sv */
// Drive command ramp queue.
// req_chan carries one item per handshake: opcode 0 with a received byte (F, B, L or R
// act, any other byte is ignored), or opcode 1 for one prescaled timer tick.
// rsp_chan returns exactly one item for every accepted request, holding the drive levels
// after that request: left and right PWM (for F: duty*255/100, saturated), the reverse pins and
// whether the step timer runs. csr_chan writes start_duty (index 0), duty_step (index 1)
// and period_ticks (index 2); other indexes are accepted and dropped. csr writes are
// always taken and are meant to happen while the block is idle.
// A request is processed in the cycle it is accepted: the ramp, queue and timer state
// update in one pass and the result appears on rsp_chan in the next cycle. One item is
// accepted every cycle while rsp_chan takes results; the rate is set by the one-pass
// state update and the one write and one look-ahead read port of the duty ring.
// When rsp_chan stalls, the pending result is held and req_chan.ready stays high only
// if that result leaves in the same cycle, so no result is ever dropped or repeated.
// Reset (synchronous, active high) restores the register defaults 60, 10 and 31250,
// empties the ring, stops the timer and clears the drive; no clearing pass is needed.
module drive_command_ramp_queue_unit #(
   parameter int QUEUE_DEPTH = 5
) (
   input logic        clock,
   input logic        reset,
   drcq_req_if.sink   req_chan,
   drcq_rsp_if.source rsp_chan,
   drcq_csr_if.sink   csr_chan
);
   import drcq_pkg::*;

   logic [DUTY_W-1:0] start_duty_ff;
   logic [DUTY_W-1:0] duty_step_ff;
   logic [TICK_W-1:0] period_ticks_ff;
   logic              rsp_valid_ff;

   logic              accept;
   queue_req_type     queue_req;
   queue_stat_type    queue_stat;
   drive_type         drive;
   logic              timer_on;

   // A new item may enter whenever the result slot is empty or being emptied.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_duty_ff   <= START_DUTY_RESET;
         duty_step_ff    <= DUTY_STEP_RESET;
         period_ticks_ff <= PERIOD_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_START_DUTY:   start_duty_ff   <= csr_chan.data[DUTY_W-1:0];
            CSR_DUTY_STEP:    duty_step_ff    <= csr_chan.data[DUTY_W-1:0];
            CSR_PERIOD_TICKS: period_ticks_ff <= csr_chan.data[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The drive registers only change on an accepted item, so they double as the
   // result payload while the result waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   drcq_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .opcode       (req_chan.opcode),
      .byte_value   (req_chan.byte_value),
      .start_duty   (start_duty_ff),
      .duty_step    (duty_step_ff),
      .period_ticks (period_ticks_ff),
      .queue_stat   (queue_stat),
      .queue_req    (queue_req),
      .drive        (drive),
      .timer_on     (timer_on)
   );

   drcq_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .queue_req  (queue_req),
      .queue_stat (queue_stat)
   );

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.left_pwm      = drive.left_pwm;
   assign rsp_chan.left_reverse  = drive.left_reverse;
   assign rsp_chan.right_pwm     = drive.right_pwm;
   assign rsp_chan.right_reverse = drive.right_reverse;
   assign rsp_chan.timer_running = timer_on;

endmodule
